// ----- hdl/terminal_line_editor_assert.svh -----
// Assertion macros for the terminal line editor.
// Used by the top level; depends on nothing else.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tle_pkg.sv -----
// Shared constants, codes and control structures of the terminal line editor.
// Depends on nothing; used by the controller, datapath and top level.
package tle_pkg;

    localparam int LINE_DEPTH_DEF = 32;
    localparam int POS_W          = 6;
    localparam int BYTE_W         = 8;
    localparam int CH_W           = 2;

    localparam logic [POS_W-1:0] LIMIT_RESET = 6'd32;

    typedef logic [CH_W-1:0] t_chan;
    localparam t_chan CH_ECHO = 2'd0;
    localparam t_chan CH_LINE = 2'd1;
    localparam t_chan CH_END  = 2'd2;

    localparam logic [BYTE_W-1:0] C_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] C_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] C_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] C_ESC = 8'h1B;
    localparam logic [BYTE_W-1:0] C_DEL = 8'h7F;
    localparam logic [BYTE_W-1:0] C_LBR = 8'h5B;
    localparam logic [BYTE_W-1:0] C_ONE = 8'h31;
    localparam logic [BYTE_W-1:0] C_P   = 8'h50;
    localparam logic [BYTE_W-1:0] C_BEL = 8'h07;

    typedef enum logic [1:0] {
        SEL_BYTE,
        SEL_CONST,
        SEL_LINE,
        SEL_LEN
    } t_sel;

    typedef struct packed {
        logic              load_byte;
        logic              store;
        logic              dec;
        logic              clr;
        logic              idx_clr;
        logic              idx_inc;
        logic              emit;
        t_sel              sel;
        logic [BYTE_W-1:0] konst;
        t_chan             chan;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic idle_tick;
        logic is_cr;
        logic is_esc;
        logic is_del;
        logic is_lbr;
        logic cur_zero;
        logic room;
        logic idx_last;
        logic slot_free;
    } t_stat;

endpackage

// ----- hdl/tle_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
// Depends on nothing.
interface tle_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, action, rx_byte, input ready);
    modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface tle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] channel;
    logic [7:0] data;
    logic       last;

    modport source (output valid, channel, data, last, input ready);
    modport sink   (input valid, channel, data, last, output ready);
endinterface

// ----- hdl/tle_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tle_ctrl.sv -----
// Controller of the terminal line editor: escape parser and beat sequencer.
// Depends on tle_pkg; drives the datapath through t_cmd and reads t_stat.
module tle_ctrl
    import tle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_ECHO = 12'b0000_0000_0010,
        S_BEL  = 12'b0000_0000_0100,
        S_CR   = 12'b0000_0000_1000,
        S_LF   = 12'b0000_0001_0000,
        S_LINE = 12'b0000_0010_0000,
        S_END  = 12'b0000_0100_0000,
        S_BS   = 12'b0000_1000_0000,
        S_ESC  = 12'b0001_0000_0000,
        S_LBR  = 12'b0010_0000_0000,
        S_ONE  = 12'b0100_0000_0000,
        S_P    = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_CSI
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    t_cmd   w_cmd;
    logic   w_free;

    assign w_free     = i_stat.slot_free;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        w_cmd     = '0;
        w_cmd.sel = SEL_CONST;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (r_mode)
                        MODE_ESC: begin
                            if (i_stat.idle_tick) begin
                                n_state = S_BEL;
                                n_mode  = MODE_TEXT;
                            end else if (i_stat.is_lbr) begin
                                n_mode = MODE_CSI;
                            end else begin
                                n_mode = MODE_TEXT;
                            end
                        end
                        MODE_CSI: begin
                            if (!i_stat.idle_tick) begin
                                n_mode = MODE_TEXT;
                            end
                        end
                        MODE_TEXT: begin
                            priority if (i_stat.idle_tick) begin
                                n_mode = MODE_TEXT;
                            end else if (i_stat.is_cr) begin
                                w_cmd.idx_clr = 1'b1;
                                n_state       = S_CR;
                            end else if (i_stat.is_esc) begin
                                n_mode = MODE_ESC;
                            end else if (i_stat.is_del) begin
                                if (!i_stat.cur_zero) begin
                                    w_cmd.dec = 1'b1;
                                    n_state   = S_BS;
                                end
                            end else if (i_stat.room) begin
                                w_cmd.store     = 1'b1;
                                w_cmd.load_byte = 1'b1;
                                n_state         = S_ECHO;
                            end
                        end
                        default: begin
                            n_mode = MODE_TEXT;
                        end
                    endcase
                end
            end
            S_ECHO: begin
                w_cmd.sel  = SEL_BYTE;
                w_cmd.chan = CH_ECHO;
                w_cmd.last = 1'b1;
                w_cmd.emit = w_free;
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            S_BEL: begin
                w_cmd.konst = C_BEL;
                w_cmd.chan  = CH_ECHO;
                w_cmd.last  = 1'b1;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CR: begin
                w_cmd.konst = C_CR;
                w_cmd.chan  = CH_ECHO;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = S_LF;
                end
            end
            S_LF: begin
                w_cmd.konst = C_LF;
                w_cmd.chan  = CH_ECHO;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = i_stat.cur_zero ? S_END : S_LINE;
                end
            end
            S_LINE: begin
                w_cmd.sel     = SEL_LINE;
                w_cmd.chan    = CH_LINE;
                w_cmd.emit    = w_free;
                w_cmd.idx_inc = w_free;
                if (w_free && i_stat.idx_last) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                w_cmd.sel  = SEL_LEN;
                w_cmd.chan = CH_END;
                w_cmd.last = 1'b1;
                w_cmd.emit = w_free;
                w_cmd.clr  = w_free;
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            S_BS: begin
                w_cmd.konst = C_BS;
                w_cmd.chan  = CH_ECHO;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = S_ESC;
                end
            end
            S_ESC: begin
                w_cmd.konst = C_ESC;
                w_cmd.chan  = CH_ECHO;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = S_LBR;
                end
            end
            S_LBR: begin
                w_cmd.konst = C_LBR;
                w_cmd.chan  = CH_ECHO;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = S_ONE;
                end
            end
            S_ONE: begin
                w_cmd.konst = C_ONE;
                w_cmd.chan  = CH_ECHO;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = S_P;
                end
            end
            S_P: begin
                w_cmd.konst = C_P;
                w_cmd.chan  = CH_ECHO;
                w_cmd.last  = 1'b1;
                w_cmd.emit  = w_free;
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_TEXT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

// ----- hdl/tle_dp.sv -----
// Datapath of the terminal line editor: limit register, cursor, line store,
// read index and output register. Depends on tle_pkg and tle_ram.
module tle_dp
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [POS_W-1:0]  i_cfg_wdata,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_chan             o_channel,
    output logic [BYTE_W-1:0] o_data,
    output logic              o_last
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(LINE_DEPTH);

    logic [POS_W-1:0]  r_limit;
    logic [POS_W-1:0]  r_cursor, n_cursor;
    logic [POS_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_byte;
    logic              r_out_valid;
    t_chan             r_channel;
    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_last;
    logic [POS_W-1:0]  w_limit;
    logic [BYTE_W-1:0] w_rdata;

    always_comb begin
        priority if (r_limit < 6'd2) begin
            w_limit = 6'd2;
        end else if (r_limit > DEPTH_POS) begin
            w_limit = DEPTH_POS;
        end else begin
            w_limit = r_limit;
        end
    end

    assign o_stat.idle_tick = i_action;
    assign o_stat.is_cr     = (i_rx_byte == C_CR);
    assign o_stat.is_esc    = (i_rx_byte == C_ESC);
    assign o_stat.is_del    = (i_rx_byte == C_DEL);
    assign o_stat.is_lbr    = (i_rx_byte == C_LBR);
    assign o_stat.cur_zero  = (r_cursor == '0);
    assign o_stat.room      = (r_cursor < (w_limit - 6'd1));
    assign o_stat.idx_last  = ((r_idx + 6'd1) == r_cursor);
    assign o_stat.slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_cursor = r_cursor;
        priority if (i_cmd.clr) begin
            n_cursor = '0;
        end else if (i_cmd.store) begin
            n_cursor = r_cursor + 6'd1;
        end else if (i_cmd.dec) begin
            n_cursor = r_cursor - 6'd1;
        end
    end

    always_comb begin
        n_idx = r_idx;
        priority if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 6'd1;
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_BYTE:  n_data = r_byte;
            SEL_CONST: n_data = i_cmd.konst;
            SEL_LINE:  n_data = w_rdata;
            SEL_LEN:   n_data = {{(BYTE_W-POS_W){1'b0}}, r_cursor};
            default:   n_data = i_cmd.konst;
        endcase
    end

    tle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_cursor[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_cursor    <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_cursor <= n_cursor;
            r_idx    <= n_idx;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.emit) begin
            r_channel <= i_cmd.chan;
            r_data    <= n_data;
            r_last    <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_channel;
    assign o_data      = r_data;
    assign o_last      = r_last;

endmodule

// ----- hdl/terminal_line_editor.sv -----
// Terminal line editor. Input beats carry a console byte or an idle tick;
// result beats carry echo bytes, the finished line and a line-end length.
// The input channel is ready whenever the sequencer is idle. A beat that
// causes results moves the sequencer from idle to its first result state,
// which loads the output register; then one result per clock follows
// while the receiver takes them. Beats that cause no result are taken at
// one per clock. The line store is read at the next index every cycle,
// so a streamed line byte is ready as soon as the output register frees.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits with it.
// The line limit register is written through i_cfg_we and i_cfg_wdata.
// A synchronous reset empties the line, clears the escape parser, sets
// the limit to 32 and drops any pending result; the store is not cleared.
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tle_in_if.sink           i_in,
    tle_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tle_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_action    (i_in.action),
        .i_rx_byte   (i_in.rx_byte),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_channel   (o_out.channel),
        .o_data      (o_out.data),
        .o_last      (o_out.last)
    );

`include "terminal_line_editor_assert.svh"

    `TLE_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_stat.slot_free, "beat issued into a full output register")
    `TLE_ASSERT_IMPL(a_store_room, i_clk, i_rst_n, w_cmd.store, w_stat.room, "character stored without room")
    `TLE_ASSERT_IMPL(a_end_last, i_clk, i_rst_n, o_out.valid && o_out.channel == CH_END, o_out.last, "line end beat without last")
    `TLE_ASSERT_NEXT(a_clr_idle, i_clk, i_rst_n, w_cmd.clr, i_in.ready, "sequencer busy after line end")

endmodule
